### hw/rtl/sme_pkg.sv
// Package: shared types, codes and tables of the sprite motion engine.
package sme_pkg;

  typedef enum logic [2:0] {
    KIND_DEFINE = 3'd0,
    KIND_START  = 3'd1,
    KIND_CUT    = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_CANCEL = 3'd4,
    KIND_POS    = 3'd5,
    KIND_TICK   = 3'd6,
    KIND_QUERY  = 3'd7
  } kind_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDEF     = 3'd1;
  localparam logic [2:0] ST_HIT       = 3'd2;
  localparam logic [2:0] ST_NONE      = 3'd3;
  localparam logic [2:0] ST_QUERY_BAD = 3'd4;

  localparam logic [15:0] HOME_POS = 16'd120;
  localparam int unsigned BOX      = 16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [3:0]  character;
    logic [3:0]  direction;
    logic [7:0]  speed;
    logic [7:0]  distance;
    logic        behind_bg;
    logic [1:0]  palette;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  out_slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]  tile_base;
    logic        frame_select;
    logic        shown;
    logic        defined_flag;
    logic        moving;
    logic [2:0]  status;
    logic [2:0]  hit_slot;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_APPLY, S_SCAN, S_EMIT, S_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_cmd;
    logic       apply;
    logic       scan_step;
    logic [2:0] scan_idx;
    logic       capture;
    logic       clear_found;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic       is_tick;
    logic       in_range;
    logic       emits;
    logic       scan_hit;
    logic       query_done;
  } sts_t;

  function automatic logic [7:0] pose_tile(input logic [3:0] c, input logic p);
    logic [7:0] a, b;
    begin
      unique case (c)
        4'd0:  begin a = 8'd0;   b = 8'd4;   end
        4'd1:  begin a = 8'd28;  b = 8'd32;  end
        4'd2:  begin a = 8'd56;  b = 8'd60;  end
        4'd3:  begin a = 8'd64;  b = 8'd68;  end
        4'd4:  begin a = 8'd96;  b = 8'd100; end
        4'd5:  begin a = 8'd88;  b = 8'd92;  end
        4'd6:  begin a = 8'd112; b = 8'd116; end
        4'd7:  begin a = 8'd120; b = 8'd124; end
        4'd8:  begin a = 8'd160; b = 8'd160; end
        4'd9:  begin a = 8'd164; b = 8'd168; end
        4'd10: begin a = 8'd176; b = 8'd180; end
        4'd11: begin a = 8'd184; b = 8'd188; end
        4'd12: begin a = 8'd192; b = 8'd196; end
        4'd13: begin a = 8'd200; b = 8'd204; end
        4'd14: begin a = 8'd208; b = 8'd210; end
        default: begin a = 8'd144; b = 8'd148; end
      endcase
      pose_tile = p ? b : a;
    end
  endfunction

  function automatic logic [15:0] step_dx(input logic [3:0] d);
    case (d)
      4'd2, 4'd3, 4'd4: step_dx = 16'd2;
      4'd6, 4'd7, 4'd8: step_dx = 16'hFFFE;
      default:          step_dx = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] step_dy(input logic [3:0] d);
    case (d)
      4'd1, 4'd2, 4'd8: step_dy = 16'hFFFE;
      4'd4, 4'd5, 4'd6: step_dy = 16'd2;
      default:          step_dy = 16'd0;
    endcase
  endfunction

endpackage

### hw/rtl/sme_if.sv
// Interface: valid/ready channel carrying one word of a given type.
interface sme_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sprite_motion_engine_unit.sv
// A command is accepted only in idle, so a new one waits until the previous one is done;
//   a query scans the slots until a hit, and a tick emits one word per stepped slot.
// Tick words are held one slot back so the final one carries last.
// Reset (rst, synchronous): all slots undefined at (120,120), plane disabled; flop table.
// Top level: sprite motion engine, command in, slot view words out, APB config.
module sprite_motion_engine_unit
  import sme_pkg::*;
#(
  parameter int unsigned MOVE_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  sme_if.sink         cmd,
  sme_if.source       res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic plane_enable;
  ctl_t ctl;
  sts_t sts;
  res_t view;
  logic out_load, out_free, had_prev;
  res_t pend;
  logic pend_v;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {31'd0, plane_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) plane_enable <= 1'b0;
    else if (psel && penable && pwrite && paddr == 2'd0) plane_enable <= pwdata[0];
  end

  sme_ctrl #(.SLOTS(MOVE_SLOTS)) u_ctrl (
    .clk, .rst, .in_valid(cmd.valid), .in_ready(cmd.ready),
    .sts, .ctl, .out_load, .out_free);

  sme_datapath #(.SLOTS(MOVE_SLOTS)) u_dp (
    .clk, .rst, .in_cmd(cmd.data), .plane_enable, .ctl, .sts,
    .res(view), .res_last_tick(had_prev));

  // tick results pass through a hold stage so last lands on the final one
  logic is_tick_now;
  assign is_tick_now = sts.is_tick;
  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (ctl.capture && (!is_tick_now || pend_v)) res.valid <= 1'b1;
      else if (res.valid && res.ready) res.valid <= 1'b0;
      if (ctl.capture) begin
        if (is_tick_now) begin
          if (pend_v) res.data <= {pend[$bits(res_t)-1:1], !out_load};
          pend_v <= out_load;
          pend   <= view;
        end else begin
          res.data <= view;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |-> !pend_v) else $error("pending result at accept");
  a_hold_tick: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> is_tick_now) else $error("pending word outside tick");
  a_prev: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> had_prev) else $error("pending without step");
`endif
endmodule

### hw/rtl/sme_ctrl.sv
// Controller: sequences command apply, slot scan and result delivery.
module sme_ctrl
  import sme_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output ctl_t   ctl,
  output logic   out_load,
  input  logic   out_free
);
  localparam int unsigned IW = 3;

  state_t state, state_next;
  logic [IW:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ctl        = '0;
    ctl.scan_idx = idx[IW-1:0];
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_cmd = 1'b1;
          state_next   = S_APPLY;
        end
      end
      S_APPLY: begin
        idx_next = '0;
        ctl.clear_found = 1'b1;
        if (sts.is_tick) begin
          state_next = S_SCAN;
        end else begin
          ctl.apply  = sts.in_range;
          state_next = sts.emits ? S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.is_tick) begin
          if (idx == (IW+1)'(SLOTS)) begin
            state_next = S_WAIT;
          end else begin
            ctl.scan_step = 1'b1;
            if (sts.scan_hit) begin
              state_next = S_EMIT;
            end else begin
              idx_next = idx + 1'b1;
            end
          end
        end else begin
          if (sts.query_done || idx == (IW+1)'(SLOTS - 1)) begin
            state_next = S_EMIT;
          end else begin
            ctl.scan_step = 1'b1;
            idx_next = idx + 1'b1;
          end
          if (idx != (IW+1)'(SLOTS)) ctl.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.capture = 1'b1;
          out_load    = 1'b1;
          if (sts.is_tick) begin
            idx_next   = idx + 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_WAIT: begin
        if (out_free) begin
          ctl.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_load_emit: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == S_EMIT && out_free)) else $error("load outside emit");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= (IW+1)'(SLOTS)) else $error("scan index out of range");
`endif
endmodule

### hw/rtl/sme_datapath.sv
// Datapath: slot table, tick stepping, collision scan and result build.
module sme_datapath
  import sme_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t in_cmd,
  input  logic plane_enable,
  input  ctl_t ctl,
  output sts_t sts,
  output res_t res,
  output logic res_last_tick
);
  cmd_t cmd;
  logic [SLOTS-1:0] defd, act, vis, phase;
  logic [3:0]  chr   [SLOTS];
  logic [3:0]  dirs  [SLOTS];
  logic [7:0]  spd   [SLOTS];
  logic [7:0]  travel [SLOTS];
  logic [15:0] xs    [SLOTS];
  logic [15:0] ys    [SLOTS];
  logic [8:0]  rem   [SLOTS];
  logic [9:0]  cnt   [SLOTS];
  logic [2:0]  anim  [SLOTS];

  logic        found;
  logic [2:0]  hit;
  logic [2:0]  sel;
  logic        stepped_any;

  logic        valid_slot;
  logic [2:0]  s;
  logic [2:0]  i;
  logic        i_ok;
  logic [9:0]  cnt_inc;
  logic [9:0]  period;
  logic        do_step;
  logic signed [16:0] ax, ay, bx, by;
  logic        ovl;

  assign s = cmd.slot;
  assign i = ctl.scan_idx;
  assign valid_slot = ({1'b0, s} < 4'(SLOTS));
  assign i_ok = ({1'b0, i} < 4'(SLOTS));
  assign cnt_inc = cnt[i] + 10'd1;
  assign period  = (spd[i] == 8'd0) ? 10'd512 : {1'b0, spd[i], 1'b0};
  assign do_step = i_ok && defd[i] && act[i] && (cnt_inc >= period);

  assign ax = 17'(signed'(xs[s]));
  assign ay = 17'(signed'(ys[s]));
  assign bx = 17'(signed'(xs[i]));
  assign by = 17'(signed'(ys[i]));
  assign ovl = (ax < bx + 17'sd16) && (bx < ax + 17'sd16) &&
               (ay < by + 17'sd16) && (by < ay + 17'sd16);

  always_comb begin
    sts = '0;
    sts.is_tick    = (cmd.kind == KIND_TICK);
    sts.in_range   = valid_slot;
    sts.emits      = valid_slot || cmd.kind == KIND_QUERY;
    sts.scan_hit   = do_step;
    sts.query_done = !valid_slot || cmd.kind != KIND_QUERY || !defd[s] || !vis[s] ||
                     (i_ok && i != s && defd[i] && vis[i] && ovl);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_cmd) cmd <= in_cmd;
    if (ctl.clear_found) begin
      found <= 1'b0;
      hit   <= '0;
      stepped_any <= 1'b0;
    end
    if (ctl.scan_step && cmd.kind == KIND_QUERY && valid_slot && !found && i_ok &&
        i != s && defd[s] && vis[s] && defd[i] && vis[i] && ovl) begin
      found <= 1'b1;
      hit   <= i;
    end
    if (ctl.scan_step && cmd.kind == KIND_TICK && do_step) sel <= i;
    if (ctl.capture && cmd.kind == KIND_TICK) stepped_any <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      defd <= '0; act <= '0; vis <= '0; phase <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        chr[k] <= '0; dirs[k] <= '0; spd[k] <= '0; travel[k] <= '0;
        xs[k] <= HOME_POS; ys[k] <= HOME_POS;
        rem[k] <= '0; cnt[k] <= '0; anim[k] <= '0;
      end
    end else begin
      if (ctl.scan_step && cmd.kind == KIND_TICK && i_ok && defd[i] && act[i]) begin
        if (!do_step) begin
          cnt[i] <= cnt_inc;
        end else begin
          cnt[i] <= '0;
          xs[i] <= xs[i] + step_dx(dirs[i]);
          ys[i] <= ys[i] + step_dy(dirs[i]);
          rem[i] <= (rem[i] >= 9'd2) ? rem[i] - 9'd2 : 9'd0;
          if (rem[i] <= 9'd2) act[i] <= 1'b0;
          anim[i] <= anim[i] + 3'd1;
          if (anim[i] == 3'd7) phase[i] <= ~phase[i];
        end
      end
      if (ctl.apply) begin
        unique case (kind_t'(cmd.kind))
          KIND_DEFINE: begin
            chr[s]  <= cmd.character;
            dirs[s] <= (cmd.direction <= 4'd8) ? cmd.direction : 4'd0;
            spd[s]  <= cmd.speed;
            travel[s] <= cmd.distance;
            rem[s]  <= {cmd.distance, 1'b0};
            cnt[s]  <= '0;
            phase[s] <= 1'b0;
            act[s]  <= 1'b0;
            if (!defd[s]) begin
              xs[s] <= HOME_POS; ys[s] <= HOME_POS; vis[s] <= 1'b0;
            end
            defd[s] <= 1'b1;
          end
          KIND_START: begin
            if (defd[s]) begin
              if (rem[s] == 9'd0) begin
                rem[s] <= {travel[s], 1'b0};
                act[s] <= (travel[s] != 8'd0) && (dirs[s] != 4'd0);
              end else begin
                act[s] <= (dirs[s] != 4'd0);
              end
              vis[s] <= 1'b1;
            end
          end
          KIND_CUT: act[s] <= 1'b0;
          KIND_ERASE: begin
            act[s] <= 1'b0; vis[s] <= 1'b0;
          end
          KIND_CANCEL: begin
            act[s] <= 1'b0; vis[s] <= 1'b0; defd[s] <= 1'b0;
            xs[s] <= HOME_POS; ys[s] <= HOME_POS;
          end
          KIND_POS: begin
            xs[s] <= cmd.new_x; ys[s] <= cmd.new_y;
            rem[s] <= {travel[s], 1'b0};
            cnt[s] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // result view; tick results report the stepped slot
  logic [2:0] v;
  logic       start_bad;
  assign v = (cmd.kind == KIND_TICK) ? sel : s;
  assign start_bad = cmd.kind == KIND_START && !defd[s];
  assign res_last_tick = stepped_any;

  always_comb begin
    res = '0;
    res.out_slot = v;
    if (cmd.kind == KIND_TICK || valid_slot) begin
      res.pos_x        = xs[v];
      res.pos_y        = ys[v];
      res.tile_base    = pose_tile(chr[v], phase[v]);
      res.frame_select = phase[v];
      res.shown        = vis[v] && plane_enable;
      res.defined_flag = defd[v];
      res.moving       = act[v];
      if (cmd.kind == KIND_QUERY)
        res.status = !defd[s] ? ST_QUERY_BAD : (found ? ST_HIT : ST_NONE);
      else if (start_bad)
        res.status = ST_UNDEF;
      else
        res.status = ST_OK;
      res.hit_slot = found ? hit : 3'd0;
    end else begin
      res.status = ST_QUERY_BAD;
    end
    res.last = 1'b1;
  end
endmodule
